FILE: rtl/scgr_pkg.sv
`timescale 1ns / 1ps
package scgr_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 300;
  localparam int unsigned DEF_SCREEN_HEIGHT = 216;
  localparam int unsigned DEF_TILE_WIDTH    = 6;
  localparam int unsigned DEF_TILE_HEIGHT   = 12;

  localparam logic [5:0] CMD_GRAPHICS      = 6'h09;
  localparam logic [5:0] INS_MEMORY_PRESET = 6'd1;
  localparam logic [5:0] INS_BORDER_PRESET = 6'd2;
  localparam logic [5:0] INS_TILE          = 6'd6;
  localparam logic [5:0] INS_PALETTE_LOW   = 6'd30;
  localparam logic [5:0] INS_PALETTE_HIGH  = 6'd31;
  localparam logic [5:0] INS_TILE_XOR      = 6'd38;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [5:0]  command_code;
    logic [5:0]  instruction_code;
    logic [47:0] symbols_low;
    logic [47:0] symbols_high;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_item_t;

  // Convert a pair of symbols into a 12-bit colour, first symbol high.
  function automatic logic [11:0] symbol_colour(input logic [5:0] first,
                                                input logic [5:0] second);
    symbol_colour = {first[5:2], first[1:0], second[5:4], second[3:0]};
  endfunction

endpackage

FILE: rtl/subcode_graphics_renderer.sv
`timescale 1ns / 1ps
// Subcode graphics renderer.
// The in channel takes one transaction per packet or pixel read; the out
// channel returns one transaction for each pixel read and none for packets.
// Pixel colours live in a frame store of 4-bit palette indices with one
// registered read port and one write port; the palette is in flip-flops.
// One transaction is worked on at a time. A pixel read passes through the
// RDWAIT and RDOUT states before out_valid rises. A tile XOR draw walks its
// 72 pixels, reading then writing each; a plain tile only writes them.
// A memory preset whose second symbol has a zero low nibble writes every
// pixel, one per cycle (64800 by default), and a border preset walks every
// pixel once, writing only the border. Palette loads and ignored packets
// are handled in the idle state. After reset the block sweeps the frame
// store to zero, one pixel a cycle, and accepts nothing until done.
// The result is held in an output register; while the receiver stalls the
// block completes its work but takes no new transaction.
module subcode_graphics_renderer import scgr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(PIXELS);
  localparam int unsigned COL_W  = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int unsigned TW     = DEF_TILE_WIDTH;
  localparam int unsigned TH     = DEF_TILE_HEIGHT;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_FILL   = 7'b0000100,
    ST_TRD    = 7'b0001000,
    ST_TWR    = 7'b0010000,
    ST_RDWAIT = 7'b0100000,
    ST_RDOUT  = 7'b1000000
  } state_t;

  state_t           state;
  logic [ADDR_W-1:0] addr;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             border_mode;
  logic [3:0]       colour;
  logic [3:0]       c0, c1;
  logic             use_xor;
  logic [71:0]      tile_bits;
  logic [3:0]       ti;
  logic [2:0]       tj;
  logic [ADDR_W-1:0] row_base;
  logic [11:0]      palette [16];
  logic [15:0]      rd_addr_q;
  logic             rd_in_range;

  logic [ADDR_W-1:0] mem_rd_addr;
  logic [3:0]        mem_rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [3:0]        mem_wr_data;

  logic [5:0] d [16];
  logic [ADDR_W-1:0] tile_top, tile_left;
  logic              tile_fits;
  logic              pix_bit;
  logic [3:0]        tile_colour;
  logic [11:0]       pal_col;
  logic              border_hit;

  scgr_frame_store #(.DEPTH(PIXELS), .ADDR_W(ADDR_W)) u_store (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Split the packet into its sixteen symbols.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      d[i]     = in_data.symbols_low[6*i +: 6];
      d[i + 8] = in_data.symbols_high[6*i +: 6];
    end
  end

  // Tile placement and screen check.
  assign tile_top  = ADDR_W'(d[2][4:0]) * ADDR_W'(TH);
  assign tile_left = ADDR_W'(d[3][5:0]) * ADDR_W'(TW);
  assign tile_fits = (32'(tile_top) + TH <= SCREEN_HEIGHT) &&
                     (32'(tile_left) + TW <= SCREEN_WIDTH);

  // Current tile pixel colour, rows stored with row 0 in the top bits.
  assign pix_bit     = tile_bits[71 - (32'(ti) * 6 + 32'(tj))];
  assign tile_colour = pix_bit ? c1 : c0;

  // Border membership of the current sweep position.
  assign border_hit = (32'(row) < TH) || (32'(row) >= SCREEN_HEIGHT - TH) ||
                      (32'(col) < TW) || (32'(col) >= SCREEN_WIDTH - TW);

  assign in_ready = (state == ST_IDLE) && !out_valid;

  // Memory port control.
  always_comb begin
    mem_rd_addr = addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr;
    mem_wr_data = colour;
    case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = '0;
      end
      ST_FILL: begin
        mem_wr_en = !border_mode || border_hit;
      end
      ST_TRD: begin
        mem_wr_en   = !use_xor;
        mem_wr_data = tile_colour;
      end
      ST_TWR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data ^ tile_colour;
      end
      ST_IDLE: begin
        mem_rd_addr = ADDR_W'(in_data.read_address);
      end
      ST_RDWAIT: begin
        // Keep the read address so the read data stays put for the result.
        mem_rd_addr = ADDR_W'(rd_addr_q);
      end
      default: begin
      end
    endcase
  end

  assign pal_col = palette[mem_rd_data];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      addr      <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 16; k++) begin
        palette[k] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (32'(addr) == PIXELS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_data.operation == OP_READ) begin
              rd_addr_q   <= in_data.read_address;
              rd_in_range <= 32'(in_data.read_address) < PIXELS;
              state       <= ST_RDWAIT;
            end else if (in_data.command_code == CMD_GRAPHICS) begin
              case (in_data.instruction_code)
                INS_MEMORY_PRESET, INS_BORDER_PRESET: begin
                  if (in_data.instruction_code == INS_BORDER_PRESET ||
                      d[1][3:0] == 4'd0) begin
                    border_mode <= in_data.instruction_code == INS_BORDER_PRESET;
                    colour      <= d[0][3:0];
                    addr        <= '0;
                    row         <= '0;
                    col         <= '0;
                    state       <= ST_FILL;
                  end
                end
                INS_TILE, INS_TILE_XOR: begin
                  if (tile_fits) begin
                    use_xor <= in_data.instruction_code == INS_TILE_XOR;
                    c0      <= d[0][3:0];
                    c1      <= d[1][3:0];
                    for (int i = 0; i < 12; i++) begin
                      tile_bits[71 - 6*i -: 6] <= d[4 + i];
                    end
                    ti        <= '0;
                    tj        <= '0;
                    row_base  <= ADDR_W'(32'(tile_top) * SCREEN_WIDTH + 32'(tile_left));
                    addr      <= ADDR_W'(32'(tile_top) * SCREEN_WIDTH + 32'(tile_left));
                    state     <= ST_TRD;
                  end
                end
                INS_PALETTE_LOW, INS_PALETTE_HIGH: begin
                  for (int k = 0; k < 8; k++) begin
                    palette[{in_data.instruction_code == INS_PALETTE_HIGH, 3'(k)}] <=
                      symbol_colour(d[2*k], d[2*k + 1]);
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        ST_FILL: begin
          addr <= addr + 1'b1;
          if (32'(col) == SCREEN_WIDTH - 1) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          if (32'(addr) == PIXELS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_TRD: begin
          if (use_xor) begin
            state <= ST_TWR;
          end else if (32'(tj) == TW - 1) begin
            tj <= '0;
            if (32'(ti) == TH - 1) begin
              state <= ST_IDLE;
            end else begin
              ti       <= ti + 1'b1;
              row_base <= row_base + ADDR_W'(SCREEN_WIDTH);
              addr     <= row_base + ADDR_W'(SCREEN_WIDTH);
            end
          end else begin
            tj   <= tj + 1'b1;
            addr <= addr + 1'b1;
          end
        end
        ST_TWR: begin
          state <= ST_TRD;
          if (32'(tj) == TW - 1) begin
            tj <= '0;
            if (32'(ti) == TH - 1) begin
              state <= ST_IDLE;
            end else begin
              ti       <= ti + 1'b1;
              row_base <= row_base + ADDR_W'(SCREEN_WIDTH);
              addr     <= row_base + ADDR_W'(SCREEN_WIDTH);
            end
          end else begin
            tj   <= tj + 1'b1;
            addr <= addr + 1'b1;
          end
        end
        ST_RDWAIT: begin
          state <= ST_RDOUT;
        end
        ST_RDOUT: begin
          out_valid              <= 1'b1;
          out_data.pixel_address <= rd_addr_q;
          out_data.red   <= rd_in_range ? {pal_col[11:8], 4'd0} : 8'd0;
          out_data.green <= rd_in_range ? {pal_col[7:4], 4'd0} : 8'd0;
          out_data.blue  <= rd_in_range ? {pal_col[3:0], 4'd0} : 8'd0;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/scgr_frame_store.sv
`timescale 1ns / 1ps
module scgr_frame_store import scgr_pkg::*; #(
  parameter int unsigned DEPTH  = DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [3:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [3:0]        wr_data
);

  logic [3:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
